// ===== src/bel_pkg.sv =====
// ============================================================================
// bel_pkg - shared types and constants for the button lockout debouncer
// Widths, reset values, event and register codes, inter-module structs.
// ============================================================================
`default_nettype none

package bel_pkg;

    // Lockout timer width
    localparam int TIMER_WIDTH = 10;

    localparam int SCAN_WIDTH     = 8;
    localparam int LOCKOUT_WIDTH  = 10;
    localparam int CFG_IDX_WIDTH  = 2;
    localparam int CFG_DATA_WIDTH = 10;

    typedef logic [TIMER_WIDTH-1:0]    timer_t;
    typedef logic [SCAN_WIDTH-1:0]     scan_t;
    typedef logic [LOCKOUT_WIDTH-1:0]  lockout_t;
    typedef logic [CFG_IDX_WIDTH-1:0]  cfg_idx_t;
    typedef logic [CFG_DATA_WIDTH-1:0] cfg_data_t;
    typedef logic [1:0]                event_t;
    typedef logic [1:0]                btn_t;

    localparam scan_t    SCAN_RESET    = scan_t'(10);
    localparam lockout_t LOCKOUT_RESET = lockout_t'(50);

    // Register indexes
    localparam cfg_idx_t CFG_SCAN_PERIOD   = cfg_idx_t'(0);
    localparam cfg_idx_t CFG_LOCKOUT_TICKS = cfg_idx_t'(1);

    // Event codes
    localparam event_t EV_NONE = 2'd0;
    localparam event_t EV_TAP  = 2'd1;
    localparam event_t EV_DOWN = 2'd2;
    localparam event_t EV_UP   = 2'd3;

    // Held button codes
    localparam btn_t BTN_TAP  = 2'd0;
    localparam btn_t BTN_DOWN = 2'd1;
    localparam btn_t BTN_UP   = 2'd2;

    typedef struct packed {
        scan_t    scan_period;
        lockout_t lockout_ticks;
    } cfg_t;

    typedef struct packed {
        event_t evt;
        logic   idle;
    } fsm_status_t;

endpackage

`default_nettype wire

// ===== src/button_event_lockout_debouncer.sv =====
// ============================================================================
// button_event_lockout_debouncer - pushbutton debouncer with lockout
// One tick per request; emits one button event per tick through a
// registered input stage and a registered result stage.
// ============================================================================
//
// Channel  Dir  Handshake               Payload
// -------  ---  ----------------------  ---------------------------------------
// in       in   in_valid / in_stall     tap_rest_level, octave_down_level,
//                                       octave_up_level
// out      out  out_valid / out_stall   button_event
// cfg      in   cfg_valid / cfg_ready   cfg_index, cfg_data
//
// Flow: one request per clock sustained while out_stall is low; the input
//   register loads on accept, the result register when the held request
//   moves forward.
// The single state update per tick (prescaler, lockout timer, switch machine)
//   sets that rate; it sits between the two registers.
// Reset: rst_n async low; prescaler loads 10, lockout 0, machine idle,
//   scan_period 10, lockout_ticks 50.
// Stalls: out_stall holds the result register; the input register keeps
//   taking requests until it is full and cannot move forward.
// cfg_ready is always high; writes take effect on the next processed tick.
// ============================================================================
`default_nettype none

module button_event_lockout_debouncer (
    input  wire logic              clk,
    input  wire logic              rst_n,
    // tick requests
    input  wire logic              in_valid,
    output logic                   in_stall,
    input  wire logic              tap_rest_level,
    input  wire logic              octave_down_level,
    input  wire logic              octave_up_level,
    // results
    output logic                   out_valid,
    input  wire logic              out_stall,
    output bel_pkg::event_t         button_event,
    // configuration
    input  wire logic              cfg_valid,
    output logic                   cfg_ready,
    input  wire bel_pkg::cfg_idx_t  cfg_index,
    input  wire bel_pkg::cfg_data_t cfg_data
);

    bel_pkg::cfg_t        cfg;
    bel_pkg::fsm_status_t fsm_status;

    // Input register
    logic s1_valid_reg, s1_valid_next;
    logic s1_tap_reg, s1_down_reg, s1_up_reg;

    // Result register
    logic            out_valid_reg, out_valid_next;
    bel_pkg::event_t out_event_reg;

    logic in_accept;
    logic advance;

    // The held request moves forward when the result slot is free or draining.
    assign advance   = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall  = s1_valid_reg && !advance;
    assign in_accept = in_valid && !in_stall;

    assign s1_valid_next  = in_accept ? 1'b1 : (advance ? 1'b0 : s1_valid_reg);
    assign out_valid_next = advance ? 1'b1 : (out_valid_reg && out_stall);

    bel_cfg_regs u_cfg_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    bel_switch_fsm u_switch_fsm (
        .clk               (clk),
        .rst_n             (rst_n),
        .step_en           (advance),
        .tap_rest_level    (s1_tap_reg),
        .octave_down_level (s1_down_reg),
        .octave_up_level   (s1_up_reg),
        .cfg               (cfg),
        .status            (fsm_status)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_tap_reg  <= tap_rest_level;
            s1_down_reg <= octave_down_level;
            s1_up_reg   <= octave_up_level;
        end
        if (advance)
            out_event_reg <= fsm_status.evt;
    end

    assign out_valid    = out_valid_reg;
    assign button_event = out_event_reg;

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------

    // A processed tick always lands in the result register.
    a_advance_fills_out: assert property (
        @(posedge clk) disable iff (!rst_n)
        advance |=> out_valid_reg
    ) else $error("processed tick did not reach result register");

    // A held request that cannot move forward is not dropped.
    a_s1_kept: assert property (
        @(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !advance) |=> s1_valid_reg
    ) else $error("input register lost a request");

    // An emitted event always takes the machine out of idle.
    a_event_leaves_idle: assert property (
        @(posedge clk) disable iff (!rst_n)
        (advance && (fsm_status.evt != bel_pkg::EV_NONE)) |=> !fsm_status.idle
    ) else $error("event emitted but machine stayed idle");

    // Events come only from idle.
    a_event_from_idle: assert property (
        @(posedge clk) disable iff (!rst_n)
        (fsm_status.evt != bel_pkg::EV_NONE) |-> fsm_status.idle
    ) else $error("event outside idle phase");

endmodule

`default_nettype wire

// ===== src/bel_cfg_regs.sv =====
// ============================================================================
// bel_cfg_regs - configuration register file
// Holds scan period and lockout reload; writes to unused indexes are dropped.
// ============================================================================
`default_nettype none

module bel_cfg_regs (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cfg_valid,
    output logic                   cfg_ready,
    input  wire bel_pkg::cfg_idx_t  cfg_index,
    input  wire bel_pkg::cfg_data_t cfg_data,
    output bel_pkg::cfg_t           cfg
);

    bel_pkg::scan_t    scan_period_reg;
    bel_pkg::lockout_t lockout_ticks_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_period_reg   <= bel_pkg::SCAN_RESET;
            lockout_ticks_reg <= bel_pkg::LOCKOUT_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                bel_pkg::CFG_SCAN_PERIOD:
                    scan_period_reg <= cfg_data[bel_pkg::SCAN_WIDTH-1:0];
                bel_pkg::CFG_LOCKOUT_TICKS:
                    lockout_ticks_reg <= cfg_data[bel_pkg::LOCKOUT_WIDTH-1:0];
                default:
                begin
                end
            endcase
        end
    end

    assign cfg.scan_period   = scan_period_reg;
    assign cfg.lockout_ticks = lockout_ticks_reg;

endmodule

`default_nettype wire

// ===== src/bel_switch_fsm.sv =====
// ============================================================================
// bel_switch_fsm - prescaler, lockout timer and switch state machine
// State advances once per processed tick; event is combinational on state and pin levels.
// ============================================================================
`default_nettype none

module bel_switch_fsm (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          step_en,
    input  wire logic          tap_rest_level,
    input  wire logic          octave_down_level,
    input  wire logic          octave_up_level,
    input  wire bel_pkg::cfg_t cfg,
    output bel_pkg::fsm_status_t status
);

    typedef enum logic [3:0] {
        PH_IDLE    = 4'b0001,
        PH_WAIT    = 4'b0010,
        PH_RELEASE = 4'b0100,
        PH_WAIT2   = 4'b1000
    } phase_t;

    phase_t            phase_reg, phase_next;
    bel_pkg::scan_t    scan_reg, scan_next;
    bel_pkg::timer_t   lock_reg, lock_next;
    bel_pkg::btn_t     held_reg, held_next;
    bel_pkg::event_t   evt;
    bel_pkg::scan_t    scan_dec;
    bel_pkg::timer_t   lock_dec;
    bel_pkg::timer_t   lock_reload;
    logic              held_released;

    assign lock_reload = bel_pkg::timer_t'(cfg.lockout_ticks);

    always_comb
    begin
        case (held_reg)
            bel_pkg::BTN_TAP:  held_released = tap_rest_level;
            bel_pkg::BTN_DOWN: held_released = octave_down_level;
            bel_pkg::BTN_UP:   held_released = octave_up_level;
            default:           held_released = 1'b1;
        endcase
    end

    always_comb
    begin
        scan_dec   = (scan_reg != '0) ? scan_reg - 1'b1 : scan_reg;
        lock_dec   = (lock_reg != '0) ? lock_reg - 1'b1 : lock_reg;
        scan_next  = scan_dec;
        lock_next  = lock_dec;
        phase_next = phase_reg;
        held_next  = held_reg;
        evt        = bel_pkg::EV_NONE;

        if (scan_dec == '0)
        begin
            scan_next = cfg.scan_period;
            case (phase_reg)
                PH_IDLE:
                begin
                    // fixed priority: tap/rest, down, up
                    if (!tap_rest_level)
                    begin
                        evt       = bel_pkg::EV_TAP;
                        held_next = bel_pkg::BTN_TAP;
                    end
                    else if (!octave_down_level)
                    begin
                        evt       = bel_pkg::EV_DOWN;
                        held_next = bel_pkg::BTN_DOWN;
                    end
                    else if (!octave_up_level)
                    begin
                        evt       = bel_pkg::EV_UP;
                        held_next = bel_pkg::BTN_UP;
                    end
                    if (evt != bel_pkg::EV_NONE)
                    begin
                        phase_next = PH_WAIT;
                        lock_next  = lock_reload;
                    end
                end
                PH_WAIT:
                begin
                    if (lock_dec == '0)
                        phase_next = PH_RELEASE;
                end
                PH_RELEASE:
                begin
                    if (held_released)
                    begin
                        phase_next = PH_WAIT2;
                        lock_next  = lock_reload;
                    end
                end
                PH_WAIT2:
                begin
                    if (lock_dec == '0)
                        phase_next = PH_IDLE;
                end
                default:
                    phase_next = PH_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            scan_reg  <= bel_pkg::SCAN_RESET;
            lock_reg  <= '0;
            held_reg  <= bel_pkg::BTN_TAP;
        end
        else if (step_en)
        begin
            phase_reg <= phase_next;
            scan_reg  <= scan_next;
            lock_reg  <= lock_next;
            held_reg  <= held_next;
        end
    end

    assign status.evt  = evt;
    assign status.idle = (phase_reg == PH_IDLE);

endmodule

`default_nettype wire

// ===== tb/button_event_lockout_debouncer_tb.sv =====
`timescale 1ns / 1ps
// ============================================================================
// button_event_lockout_debouncer_tb - self-checking bench for the debouncer
// Drives one tick request per item, runs a cycle-exact predictor of the
// prescaler, lockout timer and switch machine, and compares every result in
// order. Directed checks of the reset values, priority, release tracking and
// the zero scan period come first, then random press/release gestures over
// several register settings and handshake pacing modes.
// ============================================================================

module button_event_lockout_debouncer_tb;

    import bel_pkg::*;

    // Switch machine phases, as the predictor tracks them
    typedef enum logic [1:0] {
        PH_IDLE    = 2'd0,
        PH_WAIT    = 2'd1,
        PH_RELEASE = 2'd2,
        PH_WAIT2   = 2'd3
    } phase_e;

    // Handshake pacing modes
    typedef enum int {
        PACE_NONE,
        PACE_SENDER,
        PACE_RECEIVER,
        PACE_BOTH
    } pace_e;

    // Register indexes that decode to nothing
    localparam cfg_idx_t CFG_SPARE_A = cfg_idx_t'(2);
    localparam cfg_idx_t CFG_SPARE_B = cfg_idx_t'(3);

    // Pin patterns: bit 0 tap/rest, bit 1 octave down, bit 2 octave up;
    // a pin reads 0 while its button is held.
    localparam logic [2:0] ALL_RELEASED = 3'b111;
    localparam logic [2:0] ALL_PRESSED  = 3'b000;

    // Lines printed for mismatches before going quiet
    localparam int MAX_REPORTS = 20;

    logic      clk = 1'b0;
    logic      rst_n;
    logic      in_valid;
    logic      in_stall;
    logic      tap_rest_level;
    logic      octave_down_level;
    logic      octave_up_level;
    logic      out_valid;
    logic      out_stall = 1'b0;
    event_t    button_event;
    logic      cfg_valid;
    logic      cfg_ready;
    cfg_idx_t  cfg_index;
    cfg_data_t cfg_data;

    // Predicted state of the block
    scan_t    cfg_scan;
    lockout_t cfg_lock;
    scan_t    scan_cd;
    timer_t   lock_cd;
    phase_e   sw_phase;
    btn_t     held_btn;

    event_t pending_events[$];  // events owed by the block, oldest first
    int     mismatch_count = 0;
    int     ticks_sent = 0;
    int     gap_pct = 0;        // chance per cycle that the sender idles
    int     stall_pct = 0;      // chance per cycle that the receiver stalls

    button_event_lockout_debouncer dut (
        .clk               (clk),
        .rst_n             (rst_n),
        .in_valid          (in_valid),
        .in_stall          (in_stall),
        .tap_rest_level    (tap_rest_level),
        .octave_down_level (octave_down_level),
        .octave_up_level   (octave_up_level),
        .out_valid         (out_valid),
        .out_stall         (out_stall),
        .button_event      (button_event),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data)
    );

    always #1 clk = ~clk;

    // ------------------------------------------------------------------------
    // Predictor: one system tick. Both counters step down first; only when
    // the prescaler lands on zero does it reload and the machine advance.
    // ------------------------------------------------------------------------
    function automatic event_t debounce_tick(input logic [2:0] levels);
        logic [3:0] pins;
        event_t     evt;
        pins = {1'b1, levels};  // a held code of three would read as released
        evt = EV_NONE;
        if (scan_cd != '0)
            scan_cd = scan_cd - 1'b1;
        if (lock_cd != '0)
            lock_cd = lock_cd - 1'b1;
        if (scan_cd == '0)
        begin
            scan_cd = cfg_scan;
            case (sw_phase)
                PH_IDLE:
                begin
                    // fixed priority: tap/rest, then down, then up
                    if (!levels[0])
                    begin
                        held_btn = BTN_TAP;
                        evt = EV_TAP;
                    end
                    else if (!levels[1])
                    begin
                        held_btn = BTN_DOWN;
                        evt = EV_DOWN;
                    end
                    else if (!levels[2])
                    begin
                        held_btn = BTN_UP;
                        evt = EV_UP;
                    end
                    if (evt != EV_NONE)
                    begin
                        sw_phase = PH_WAIT;
                        lock_cd = timer_t'(cfg_lock);
                    end
                end
                PH_WAIT:
                    if (lock_cd == '0)
                        sw_phase = PH_RELEASE;
                PH_RELEASE:
                    // only the button that started the event is watched
                    if (pins[held_btn])
                    begin
                        sw_phase = PH_WAIT2;
                        lock_cd = timer_t'(cfg_lock);
                    end
                default:
                    if (lock_cd == '0)
                        sw_phase = PH_IDLE;
            endcase
        end
        return evt;
    endfunction

    task automatic flag_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
            $display("mismatch at %0t: %s", $time, msg);
    endtask

    task automatic set_pacing(input pace_e mode);
        case (mode)
            PACE_SENDER:
            begin
                gap_pct = 86;
                stall_pct = 0;
            end
            PACE_RECEIVER:
            begin
                gap_pct = 0;
                stall_pct = 86;
            end
            PACE_BOTH:
            begin
                gap_pct = 13;
                stall_pct = 13;
            end
            default:
            begin
                gap_pct = 0;
                stall_pct = 0;
            end
        endcase
    endtask

    // One tick request. Returns at the edge that accepts it with in_valid
    // still high, so a following request can go out back to back.
    task automatic send_tick(input logic [2:0] levels);
        while ($urandom_range(99) < gap_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid          <= 1'b1;
        tap_rest_level    <= levels[0];
        octave_down_level <= levels[1];
        octave_up_level   <= levels[2];
        do
            @(posedge clk);
        while (in_stall !== 1'b0);
        pending_events.push_back(debounce_tick(levels));
        ticks_sent++;
    endtask

    // Sender goes quiet until every owed event is back, plus the two-stage
    // pipeline depth with margin.
    task automatic drain_results();
        in_valid <= 1'b0;
        while (pending_events.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input cfg_idx_t idx, input cfg_data_t data);
        drain_results();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (cfg_ready !== 1'b1);
        cfg_valid <= 1'b0;
        @(posedge clk);
        case (idx)
            CFG_SCAN_PERIOD:   cfg_scan = scan_t'(data);
            CFG_LOCKOUT_TICKS: cfg_lock = lockout_t'(data);
            default:           ;
        endcase
    endtask

    // Press/release gestures sized to the current settings so that the
    // machine gets through all its phases; a fifth are raw noise, and some
    // chords are let go of piecewise. Stops exactly at the item count.
    task automatic run_gestures(input int n_items);
        int         target;
        int         span;
        logic [2:0] pressed;
        target = ticks_sent + n_items;
        span = (cfg_scan == '0 ? 1 : int'(cfg_scan)) * (int'(cfg_lock) + 2);
        if (span > 40)
            span = 40;
        while (ticks_sent < target)
        begin
            if ($urandom_range(9) < 2)
            begin
                repeat ($urandom_range(1, 6))
                    if (ticks_sent < target)
                        send_tick(3'($urandom_range(7)));
            end
            else
            begin
                if ($urandom_range(3) == 0)
                    pressed = 3'($urandom_range(1, 7));
                else
                    pressed = 3'b001 << $urandom_range(2);
                repeat ($urandom_range(1, span))
                    if (ticks_sent < target)
                        send_tick(~pressed);
                if ($urandom_range(4) == 0)
                begin
                    pressed &= 3'($urandom_range(7));
                    repeat ($urandom_range(1, span))
                        if (ticks_sent < target)
                            send_tick(~pressed);
                end
                repeat ($urandom_range(1, span))
                    if (ticks_sent < target)
                        send_tick(ALL_RELEASED);
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Prescaler starts at 10: an all-pressed tick lands exactly on the first
    // step, and tap/rest wins.
    task automatic test_reset_values();
        set_pacing(PACE_NONE);
        repeat (9) send_tick(ALL_RELEASED);
        send_tick(ALL_PRESSED);
    endtask

    // Step every tick, no lockout. Walks priority, release of the held button
    // only, and the dead step on the way back to idle. Writes to the spare
    // indexes must not disturb either register.
    task automatic test_priority_and_release();
        write_reg(CFG_SCAN_PERIOD, cfg_data_t'(1));
        write_reg(CFG_LOCKOUT_TICKS, cfg_data_t'(0));
        write_reg(CFG_SPARE_A, '1);
        write_reg(CFG_SPARE_B, '1);
        set_pacing(PACE_BOTH);
        // let the reset-time lockout run out and get the machine idle
        while (!(sw_phase == PH_IDLE && scan_cd <= 1))
            send_tick(ALL_RELEASED);
        send_tick(ALL_PRESSED);     // tap/rest
        send_tick(ALL_PRESSED);     // lockout over
        send_tick(3'b001);          // tap released, others still down
        send_tick(3'b001);          // back to idle
        send_tick(3'b001);          // octave down
        send_tick(3'b001);
        send_tick(3'b101);          // up released: not the watched button
        send_tick(3'b111);          // down released
        send_tick(3'b011);          // idle again, press ignored this step
        send_tick(3'b011);          // octave up
        send_tick(3'b011);
        send_tick(ALL_RELEASED);
        send_tick(ALL_RELEASED);
        send_tick(ALL_RELEASED);
    endtask

    // A zero period reloads zero, so the machine steps on every tick.
    task automatic test_scan_period_zero();
        write_reg(CFG_SCAN_PERIOD, cfg_data_t'(0));
        write_reg(CFG_LOCKOUT_TICKS, cfg_data_t'(2));
        set_pacing(PACE_RECEIVER);
        repeat (4) send_tick(3'b110);
        repeat (4) send_tick(ALL_RELEASED);
        repeat (3) send_tick(3'b101);
        send_tick(ALL_RELEASED);
    endtask

    // Random settings per phase (the first: scan period 1, no lockout), pacing
    // modes in turn; the scan period is written with junk in the bits above its
    // width. Mid-phase the sender holds off until every result is back.
    task automatic test_random_gestures();
        scan_t scan;
        int    lock;
        for (int p = 0; p < 6; p++)
        begin
            if (p == 0)
            begin
                scan = scan_t'(1);
                lock = 0;
            end
            else
            begin
                scan = scan_t'($urandom_range(0, 4));
                lock = $urandom_range(0, 16);
            end
            write_reg(CFG_SCAN_PERIOD, {2'($urandom_range(3)), scan});
            write_reg(CFG_LOCKOUT_TICKS, cfg_data_t'(lock));
            set_pacing(pace_e'(p % 4));
            run_gestures(25);
            drain_results();
            run_gestures(25);
        end
    endtask

    // Largest scan period (upper data bits dropped) and full lockout.
    task automatic test_extreme_settings();
        write_reg(CFG_SCAN_PERIOD, '1);
        write_reg(CFG_LOCKOUT_TICKS, '1);
        set_pacing(PACE_BOTH);
        run_gestures(60);
    endtask

    // ------------------------------------------------------------------------
    // Result checker and receiver stall generator
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        event_t want;
        if (rst_n && out_valid === 1'b1 && !out_stall)
        begin
            if (pending_events.size() == 0)
            begin
                flag_mismatch($sformatf("unexpected result, button_event=%0d",
                                        button_event));
            end
            else
            begin
                want = pending_events.pop_front();
                if (button_event !== want)
                    flag_mismatch($sformatf("button_event=%0d, expected %0d",
                                            button_event, want));
            end
        end
        out_stall <= ($urandom_range(99) < stall_pct);
    end

    initial
    begin
        rst_n             = 1'b0;
        in_valid          = 1'b0;
        tap_rest_level    = 1'b1;
        octave_down_level = 1'b1;
        octave_up_level   = 1'b1;
        cfg_valid         = 1'b0;
        cfg_index         = CFG_SCAN_PERIOD;
        cfg_data          = '0;
        cfg_scan          = SCAN_RESET;
        cfg_lock          = LOCKOUT_RESET;
        scan_cd           = SCAN_RESET;
        lock_cd           = '0;
        sw_phase          = PH_IDLE;
        held_btn          = BTN_TAP;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_values();
        test_priority_and_release();
        test_scan_period_zero();
        test_random_gestures();
        test_extreme_settings();

        // flush, then watch a little longer for stray results
        drain_results();
        repeat (8) @(posedge clk);
        if (mismatch_count == 0 && pending_events.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    // Watchdog: far beyond the slowest legal run
    initial
    begin
        #1_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// ===== filelist.f =====
src/bel_pkg.sv
src/bel_cfg_regs.sv
src/bel_switch_fsm.sv
src/button_event_lockout_debouncer.sv
tb/button_event_lockout_debouncer_tb.sv
